// ===== hdl/tilt_pkg.sv =====
// package for accel_tilt_angles: widths, cordic angle table, stage count
// no dependencies
package tilt_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_SHIFT = 30 - SAMPLE_BITS;
  localparam int INT_FRAC = 30;
  localparam int OUT_BITS = ANGLE_FRAC_BITS + 2;
  localparam int SQ_BITS = 62;
  localparam int ROOT_BITS = 31;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int RND_SH = INT_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1686629713);
  localparam logic signed [OUT_BITS-1:0] ANGLE_LIM =
    OUT_BITS'((64'sd1686629713 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH);

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8; 1: t = 32'h1DAC6705; 2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6; 4: t = 32'h03FEAB76; 5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA; 7: t = 32'h007FFF55; 8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; default: t = 32'h0000007F;
    endcase
    return ZW'(signed'({1'b0, t}));
  endfunction

  // one channel word moving down the pipe
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] num;
    logic [ROOT_BITS-1:0] root;
  } chan_t;
endpackage

// ===== hdl/tilt_sqrt.sv =====
// tilt_sqrt: pipelined sum of squares and bit-by-bit floor square root
// depends on tilt_pkg
module tilt_sqrt import tilt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [SAMPLE_BITS-1:0] num,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  output logic out_valid,
  output chan_t out_chan
);
  // squares of raw samples, guard shift applied as 2*GUARD_SHIFT later
  localparam int PW = 2 * SAMPLE_BITS;
  logic v0;
  logic signed [SAMPLE_BITS-1:0] num0;
  logic [PW-1:0] aa, bb;
  logic v1;
  logic signed [SAMPLE_BITS-1:0] num1;
  logic [SQ_BITS-1:0] sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
    end
    num0 <= num;
    aa <= PW'(a * a);
    bb <= PW'(b * b);
    num1 <= num0;
    sq1 <= SQ_BITS'({1'b0, aa} + {1'b0, bb}) << (2 * GUARD_SHIFT);
  end

  // restoring root: remainder, partial root, one result bit per step
  logic [SQRT_STAGES:0] sv;
  logic signed [SAMPLE_BITS-1:0] snum [SQRT_STAGES+1];
  logic [SQ_BITS-1:0] srem [SQRT_STAGES+1];
  logic [ROOT_BITS-1:0] sroot [SQRT_STAGES+1];

  assign sv[0] = v1;
  assign snum[0] = num1;
  assign srem[0] = sq1;
  assign sroot[0] = '0;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sq
    logic [SQ_BITS-1:0] r_n;
    logic [ROOT_BITS-1:0] q_n;
    always_comb begin
      logic [SQ_BITS+1:0] trial;
      int k;
      r_n = srem[s];
      q_n = sroot[s];
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        k = SQRT_STEPS - 1 - (s * SQRT_PER_STAGE + j);
        if (k >= 0) begin
          trial = ({2'b0, q_n} << (k + 1)) + ((SQ_BITS + 2)'(1) << (2 * k));
          if ({2'b0, r_n} >= trial) begin
            r_n = SQ_BITS'({2'b0, r_n} - trial);
            q_n = q_n | (ROOT_BITS'(1) << k);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else sv[s+1] <= sv[s];
      snum[s+1] <= snum[s];
      srem[s+1] <= r_n;
      sroot[s+1] <= q_n;
    end
  end

  assign out_valid = sv[SQRT_STAGES];
  assign out_chan.num = snum[SQRT_STAGES];
  assign out_chan.root = sroot[SQRT_STAGES];
endmodule

// ===== hdl/tilt_cordic.sv =====
// tilt_cordic: vectoring cordic pipeline, one rotation per stage, round and clamp
// depends on tilt_pkg
module tilt_cordic import tilt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  chan_t in_chan,
  output logic out_valid,
  output logic signed [OUT_BITS-1:0] angle
);
  logic [CORDIC_STAGES:0] v;
  logic signed [CW-1:0] cx [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] nz, rz, ng;

  assign v[0] = in_valid;
  assign cx[0] = CW'(signed'({1'b0, in_chan.root}));
  assign cy[0] = CW'(in_chan.num) <<< GUARD_SHIFT;
  assign cz[0] = '0;
  assign nz[0] = (in_chan.num == '0);
  assign rz[0] = (in_chan.root == '0);
  assign ng[0] = in_chan.num[SAMPLE_BITS-1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign at = atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      nz[i+1] <= nz[i];
      rz[i+1] <= rz[i];
      ng[i+1] <= ng[i];
      if (!cy[i][CW-1]) begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + at;
      end else begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - at;
      end
    end
  end

  logic signed [ZW-1:0] zf, zr;
  logic signed [OUT_BITS-1:0] a_n;
  always_comb begin
    zf = rz[CORDIC_STAGES] ? (ng[CORDIC_STAGES] ? -HALF_PI : HALF_PI)
                           : cz[CORDIC_STAGES];
    zr = (zf + (ZW'(1) <<< (RND_SH - 1))) >>> RND_SH;
    if (nz[CORDIC_STAGES]) a_n = '0;
    else if (zr > ZW'(ANGLE_LIM)) a_n = ANGLE_LIM;
    else if (zr < -ZW'(ANGLE_LIM)) a_n = -ANGLE_LIM;
    else a_n = OUT_BITS'(zr);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v[CORDIC_STAGES];
    angle <= a_n;
  end
endmodule

// ===== hdl/accel_tilt_angles.sv =====
// accel_tilt_angles: pitch and roll from one accelerometer sample
// path from start to done: square and sum registers, root stages, cordic stages, angle register
// throughput: one word per cycle, busy is always low; the square root and
// cordic chains are fully pipelined, so each stage holds its own word
// reset: rst (synchronous) clears the valid bits only; done never strobes on stale data
module accel_tilt_angles import tilt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic done,
  output logic signed [OUT_BITS-1:0] pitch_angle,
  output logic signed [OUT_BITS-1:0] roll_angle
);
  // no stall path: a word enters whenever start is high
  assign busy = 1'b0;

  logic pv_s, rv_s, pv_c, rv_c;
  chan_t pch, rch;

  // pitch: x over root(y^2+z^2)
  tilt_sqrt u_sqrt_p (.clk, .rst, .in_valid(start), .num(accel_x),
    .a(accel_y), .b(accel_z), .out_valid(pv_s), .out_chan(pch));
  // roll: y over root(x^2+z^2)
  tilt_sqrt u_sqrt_r (.clk, .rst, .in_valid(start), .num(accel_y),
    .a(accel_x), .b(accel_z), .out_valid(rv_s), .out_chan(rch));

  tilt_cordic u_cor_p (.clk, .rst, .in_valid(pv_s), .in_chan(pch),
    .out_valid(pv_c), .angle(pitch_angle));
  tilt_cordic u_cor_r (.clk, .rst, .in_valid(rv_s), .in_chan(rch),
    .out_valid(rv_c), .angle(roll_angle));

  // both channels run in lockstep
  assign done = pv_c & rv_c;
endmodule

// ===== hdl/tilt_checker.sv =====
// tilt_checker: port-level checks for accel_tilt_angles, bound to the top level
// depends on tilt_pkg
module tilt_checker import tilt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [OUT_BITS-1:0] pitch_angle,
  input logic signed [OUT_BITS-1:0] roll_angle
);
  localparam int LAT = 3 + SQRT_STAGES + CORDIC_STAGES;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= ANGLE_LIM && pitch_angle >= -ANGLE_LIM))
    else $error("pitch out of range");
  a_roll_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= ANGLE_LIM && roll_angle >= -ANGLE_LIM))
    else $error("roll out of range");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("word lost");
endmodule

bind accel_tilt_angles tilt_checker u_tilt_checker (.clk, .rst, .start, .busy,
  .done, .pitch_angle, .roll_angle);
